/* rtl/cwpg_pkg.sv */
// Shared widths, register codes and arithmetic helpers of the cubic waypoint pose generator.
`timescale 1ns / 1ps

package cwpg_pkg;

   // field widths
   localparam int PUSH_HEIGHT_W = 21;
   localparam int HALF_SPAN_W   = 20;
   localparam int COUNT_W       = 7;
   localparam int INDEX_W       = 7;
   localparam int POS_Z_W       = 21;
   localparam int POS_Y_W       = 21;
   localparam int ROLL_W        = 18;
   localparam int CSR_DATA_W    = 21;
   localparam int CSR_INDEX_W   = 2;

   // reset values
   localparam logic [HALF_SPAN_W-1:0] HALF_SPAN_RESET = 20'd1000;
   localparam logic [COUNT_W-1:0]     COUNT_RESET     = 7'd1;

   // default parameter values
   localparam int DEF_MAX_POINTS      = 64;
   localparam int DEF_ANGLE_FRAC_BITS = 16;

   // roll datapath
   localparam int XA_W          = 37;
   localparam int YA_W          = 42;
   localparam int CORDIC_W      = 45;
   localparam int CORDIC_STEPS  = 30;
   localparam int ACC_BITS      = 30;
   localparam int ANG_W         = 32;
   localparam int NORM_LIMIT    = 40;
   localparam int NORM_STAGES   = 3;
   localparam int CORDIC_LAT    = NORM_STAGES + CORDIC_STEPS + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PUSH_HEIGHT    = 2'd0,
      CSR_HALF_SPAN      = 2'd1,
      CSR_WAYPOINT_COUNT = 2'd2
   } csr_index_type;

   // atan(2^-k) at 2^30 scale, truncated
   function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] k);
      logic signed [ANG_W-1:0] r;
      begin
         unique case (k)
            5'd0:  r = 32'sd843314856;
            5'd1:  r = 32'sd497837829;
            5'd2:  r = 32'sd263043836;
            5'd3:  r = 32'sd133525158;
            5'd4:  r = 32'sd67021686;
            5'd5:  r = 32'sd33543515;
            5'd6:  r = 32'sd16775850;
            5'd7:  r = 32'sd8388437;
            5'd8:  r = 32'sd4194282;
            5'd9:  r = 32'sd2097149;
            5'd10: r = 32'sd1048575;
            5'd11: r = 32'sd524287;
            5'd12: r = 32'sd262143;
            5'd13: r = 32'sd131071;
            5'd14: r = 32'sd65535;
            5'd15: r = 32'sd32767;
            5'd16: r = 32'sd16383;
            5'd17: r = 32'sd8191;
            5'd18: r = 32'sd4095;
            5'd19: r = 32'sd2047;
            5'd20: r = 32'sd1023;
            5'd21: r = 32'sd511;
            5'd22: r = 32'sd255;
            5'd23: r = 32'sd127;
            5'd24: r = 32'sd63;
            5'd25: r = 32'sd31;
            5'd26: r = 32'sd15;
            5'd27: r = 32'sd7;
            5'd28: r = 32'sd3;
            5'd29: r = 32'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // arithmetic right shift that truncates toward zero
   function automatic logic signed [CORDIC_W-1:0] shr_tz(input logic signed [CORDIC_W-1:0] v,
                                                         input logic [4:0] k);
      logic [CORDIC_W-1:0] mg;
      begin
         mg = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
         mg = mg >> k;
         return v[CORDIC_W-1] ? -$signed(mg) : $signed(mg);
      end
   endfunction

endpackage

/* rtl/cwpg_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module cwpg_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 7,
   parameter int QUO_W = 21
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int REM_W = DEN_W + QUO_W;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];

   logic [REM_W-1:0] rem_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];
   logic [DEN_W-1:0] den_src [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int K = QUO_W - 1 - j;
      logic [REM_W-1:0] trial;
      logic             ge;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_src[j] = REM_W'(num);
         assign quo_src[j] = '0;
         assign den_src[j] = den;
      end else begin : g_next
         assign rem_src[j] = rem_ff[j-1];
         assign quo_src[j] = quo_ff[j-1];
         assign den_src[j] = den_ff[j-1];
      end

      always_comb begin
         trial  = REM_W'(den_src[j]) << K;
         ge     = rem_src[j] >= trial;
         rem_in = ge ? rem_src[j] - trial : rem_src[j];
         quo_in = quo_src[j] | (QUO_W'(ge) << K);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_src[j];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

/* rtl/cwpg_cordic.sv */
// Pipelined atan(y/x): normalizing shift, vectoring CORDIC steps and final rounding.
`timescale 1ns / 1ps

module cwpg_cordic import cwpg_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic [XA_W-1:0]        x_in,
   input  logic signed [YA_W-1:0] y_in,
   output logic [ROLL_W-1:0]      roll
);

   localparam int RND_SH = ACC_BITS - DEF_ANGLE_FRAC_BITS;

   // normalize: three stages of conditional left shifts
   logic signed [CORDIC_W-1:0] n_x_ff [NORM_STAGES];
   logic signed [CORDIC_W-1:0] n_y_ff [NORM_STAGES];
   logic [CORDIC_W-1:0]        n_m_ff [NORM_STAGES];
   logic                       n_z_ff [NORM_STAGES];

   logic signed [CORDIC_W-1:0] n1_x, n1_y, n2_x, n2_y, n3_x, n3_y;
   logic [CORDIC_W-1:0]        n1_m, n2_m, n3_m;

   always_comb begin
      n1_x = CORDIC_W'($signed({1'b0, x_in}));
      n1_y = CORDIC_W'(y_in);
      n1_m = CORDIC_W'(x_in) | (y_in[YA_W-1] ? CORDIC_W'(-n1_y) : CORDIC_W'(n1_y));
      if ((n1_m >> (NORM_LIMIT - 32)) == '0) begin
         n1_x = n1_x <<< 32;
         n1_y = n1_y <<< 32;
         n1_m = n1_m << 32;
      end
      if ((n1_m >> (NORM_LIMIT - 16)) == '0) begin
         n1_x = n1_x <<< 16;
         n1_y = n1_y <<< 16;
         n1_m = n1_m << 16;
      end
   end

   always_comb begin
      n2_x = n_x_ff[0];
      n2_y = n_y_ff[0];
      n2_m = n_m_ff[0];
      if ((n2_m >> (NORM_LIMIT - 8)) == '0) begin
         n2_x = n2_x <<< 8;
         n2_y = n2_y <<< 8;
         n2_m = n2_m << 8;
      end
      if ((n2_m >> (NORM_LIMIT - 4)) == '0) begin
         n2_x = n2_x <<< 4;
         n2_y = n2_y <<< 4;
         n2_m = n2_m << 4;
      end
   end

   always_comb begin
      n3_x = n_x_ff[1];
      n3_y = n_y_ff[1];
      n3_m = n_m_ff[1];
      if ((n3_m >> (NORM_LIMIT - 2)) == '0) begin
         n3_x = n3_x <<< 2;
         n3_y = n3_y <<< 2;
         n3_m = n3_m << 2;
      end
      if ((n3_m >> (NORM_LIMIT - 1)) == '0) begin
         n3_x = n3_x <<< 1;
         n3_y = n3_y <<< 1;
         n3_m = n3_m << 1;
      end
      // one more doubling lifts the larger magnitude past 2^40
      if ((n3_m >> NORM_LIMIT) == '0) begin
         n3_x = n3_x <<< 1;
         n3_y = n3_y <<< 1;
         n3_m = n3_m << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_x_ff[0] <= n1_x;
         n_y_ff[0] <= n1_y;
         n_m_ff[0] <= n1_m;
         n_z_ff[0] <= (y_in == '0);
         n_x_ff[1] <= n2_x;
         n_y_ff[1] <= n2_y;
         n_m_ff[1] <= n2_m;
         n_z_ff[1] <= n_z_ff[0];
         n_x_ff[2] <= n3_x;
         n_y_ff[2] <= n3_y;
         n_m_ff[2] <= n3_m;
         n_z_ff[2] <= n_z_ff[1];
      end
   end

   // vectoring steps
   logic signed [CORDIC_W-1:0] c_x_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] c_y_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0]    c_a_ff [CORDIC_STEPS];
   logic                       c_z_ff [CORDIC_STEPS];

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
      logic signed [CORDIC_W-1:0] xp, yp, xs, ys, x_in_s, y_in_s;
      logic signed [ANG_W-1:0]    ap, a_in_s;
      logic                       zp;

      if (j == 0) begin : g_first
         assign xp = n_x_ff[NORM_STAGES-1];
         assign yp = n_y_ff[NORM_STAGES-1];
         assign ap = '0;
         assign zp = n_z_ff[NORM_STAGES-1];
      end else begin : g_next
         assign xp = c_x_ff[j-1];
         assign yp = c_y_ff[j-1];
         assign ap = c_a_ff[j-1];
         assign zp = c_z_ff[j-1];
      end

      always_comb begin
         xs = shr_tz(xp, 5'(j));
         ys = shr_tz(yp, 5'(j));
         if (!yp[CORDIC_W-1]) begin
            x_in_s = xp + ys;
            y_in_s = yp - xs;
            a_in_s = ap + atan_tab(5'(j));
         end else begin
            x_in_s = xp - ys;
            y_in_s = yp + xs;
            a_in_s = ap - atan_tab(5'(j));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_x_ff[j] <= x_in_s;
            c_y_ff[j] <= y_in_s;
            c_a_ff[j] <= a_in_s;
            c_z_ff[j] <= zp;
         end
      end
   end

   // round half away from zero to the output scale
   logic signed [ANG_W-1:0] ang;
   logic [ANG_W:0]          ang_mag;
   logic [ANG_W:0]          rnd;
   logic [ROLL_W-1:0]       roll_in;
   logic [ROLL_W-1:0]       roll_ff;

   always_comb begin
      ang     = c_a_ff[CORDIC_STEPS-1];
      ang_mag = ang[ANG_W-1] ? (ANG_W+1)'(-ang) : (ANG_W+1)'(ang);
      rnd     = (ang_mag + ((ANG_W+1)'(1) << (RND_SH - 1))) >> RND_SH;
      if (c_z_ff[CORDIC_STEPS-1]) begin
         roll_in = '0;
      end else if (ang[ANG_W-1]) begin
         roll_in = ROLL_W'(-rnd);
      end else begin
         roll_in = ROLL_W'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff <= roll_in;
      end
   end

   assign roll = roll_ff;

endmodule

/* rtl/cubic_waypoint_pose_generator.sv */
// Top level of the cubic waypoint pose generator: registers, polynomial pipeline, output stage.
`timescale 1ns / 1ps

// Takes a waypoint index and returns z, y and roll of a cubic push path of
// height h over the span 0..2d sampled at num steps. Fully pipelined: one
// request per cycle while the response is not stalled; the pipeline depth is
// set by the 30-step roll CORDIC plus its normalize and round stages. All stages
// advance together; a stalled response freezes the pipe, while an empty input
// stage still takes a request. CSR writes must only happen while the pipe is
// empty. Index 0 or above the effective count gives zeros and index_error.
module cubic_waypoint_pose_generator import cwpg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [INDEX_W-1:0]        req_point_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [POS_Z_W-1:0]        rsp_pos_z,
   output logic signed [POS_Y_W-1:0] rsp_pos_y,
   output logic signed [ROLL_W-1:0]  rsp_roll,
   output logic                      rsp_index_error,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   // datapath widths are sized for this point limit
   localparam int MAX_POINTS = DEF_MAX_POINTS;

   // stage numbering: S1 is the request register, S_LAST feeds the output register
   localparam int QUO_W   = POS_Z_W;
   localparam int ZN_W    = 28;
   localparam int YN_W    = 46;
   localparam int DEN_W   = 25;
   localparam int S_LAST  = 5 + CORDIC_LAT;
   localparam int Z_DLY   = S_LAST - (3 + QUO_W);
   localparam int Y_DLY   = S_LAST - (6 + QUO_W);
   localparam int SGN_DLY = S_LAST - 6;
   localparam int ERR_DLY = S_LAST - 1;

   // ---------------- CSRs ----------------
   logic signed [PUSH_HEIGHT_W-1:0] push_height_ff;
   logic [HALF_SPAN_W-1:0]          half_span_ff;
   logic [COUNT_W-1:0]              count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         push_height_ff <= '0;
         half_span_ff   <= HALF_SPAN_RESET;
         count_ff       <= COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PUSH_HEIGHT:    push_height_ff <= $signed(csr_wdata[PUSH_HEIGHT_W-1:0]);
            CSR_HALF_SPAN:      half_span_ff   <= csr_wdata[HALF_SPAN_W-1:0];
            CSR_WAYPOINT_COUNT: count_ff       <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective d and num
   logic [HALF_SPAN_W-1:0] cfg_d;
   logic [COUNT_W-1:0]     cfg_q;
   assign cfg_d = (half_span_ff == '0) ? HALF_SPAN_W'(1) : half_span_ff;
   assign cfg_q = (32'(count_ff) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : count_ff;

   // ---------------- handshake ----------------
   logic              adv;
   logic              en1;
   logic [S_LAST:1]   vld_ff;
   logic              rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign en1       = adv || !vld_ff[1];
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            vld_ff[1] <= req_valid;
         end
         if (adv) begin
            vld_ff[S_LAST:2] <= vld_ff[S_LAST-1:1];
            rsp_valid_ff     <= vld_ff[S_LAST];
         end
      end
   end

   // ---------------- S1: request register ----------------
   logic [INDEX_W-1:0] s1_idx_ff;
   logic               s1_err_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_idx_ff <= req_point_index;
         s1_err_ff <= (req_point_index == '0) || (req_point_index > cfg_q);
      end
   end

   // ---------------- S2: products of p and q ----------------
   logic [7:0]         s1_p;
   logic [7:0]         s2_p_ff;
   logic [13:0]        s2_q2_ff;
   logic [14:0]        s2_pq_ff;
   logic [15:0]        s2_p2_ff;
   logic [ZN_W-1:0]    s2_pd_ff;
   logic signed [8:0]  s2_a_ff;   // 2q - p
   logic signed [8:0]  s2_b_ff;   // q - p

   assign s1_p = {s1_idx_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p_ff  <= s1_p;
         s2_q2_ff <= 14'(cfg_q) * 14'(cfg_q);
         s2_pq_ff <= 15'(s1_p) * 15'(cfg_q);
         s2_p2_ff <= 16'(s1_p) * 16'(s1_p);
         s2_pd_ff <= ZN_W'(s1_p) * ZN_W'(cfg_d);
         s2_a_ff  <= $signed({1'b0, cfg_q, 1'b0}) - $signed({1'b0, s1_p});
         s2_b_ff  <= $signed({2'b0, cfg_q}) - $signed({1'b0, s1_p});
      end
   end

   // ---------------- S3: inner quadratic, q^3, d*q^2, z numerator ----------------
   logic [19:0]         s2_inner;
   logic [7:0]          s3_p_ff;
   logic [18:0]         s3_inner_ff;
   logic [20:0]         s3_q3_ff;
   logic signed [17:0]  s3_ab_ff;
   logic [33:0]         s3_dq2_ff;
   logic [ZN_W-1:0]     s3_zn_ff;

   assign s2_inner = 20'(s2_q2_ff) * 20'd12 + 20'(s2_p2_ff) * 20'd2 - 20'(s2_pq_ff) * 20'd9;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_p_ff     <= s2_p_ff;
         s3_inner_ff <= s2_inner[18:0];
         s3_q3_ff    <= 21'(s2_q2_ff) * 21'(cfg_q);
         s3_ab_ff    <= $signed(18'(s2_a_ff)) * $signed(18'(s2_b_ff));
         s3_dq2_ff   <= 34'(cfg_d) * 34'(s2_q2_ff);
         s3_zn_ff    <= s2_pd_ff + ZN_W'(cfg_q >> 1);
      end
   end

   // ---------------- S4: numerator polynomial, divisor, h*(2q-p)(q-p), X ----------------
   logic [27:0]         s3_pi;
   logic [DEN_W-1:0]    s4_num_ff;
   logic [DEN_W-1:0]    s4_den_ff;
   logic signed [38:0]  s4_hab_ff;
   logic [XA_W-1:0]     s4_xa_ff;

   assign s3_pi = 28'(s3_p_ff) * 28'(s3_inner_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_num_ff <= DEN_W'({s3_pi, 1'b0});
         s4_den_ff <= 25'(s3_q3_ff) * 25'd10;
         s4_hab_ff <= $signed(39'(push_height_ff)) * $signed(39'(s3_ab_ff));
         s4_xa_ff  <= 37'(s3_dq2_ff) * 37'd5;
      end
   end

   // ---------------- S5: h*N and Y ----------------
   logic signed [46:0]      s5_hn_ff;
   logic signed [YA_W-1:0]  s5_ya_ff;
   logic [XA_W-1:0]         s5_xa_ff;
   logic [DEN_W-1:0]        s5_den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_hn_ff  <= $signed(47'(push_height_ff)) * $signed({22'b0, s4_num_ff});
         s5_ya_ff  <= -($signed(YA_W'(s4_hab_ff)) * 42'sd6);
         s5_xa_ff  <= s4_xa_ff;
         s5_den_ff <= s4_den_ff;
      end
   end

   // ---------------- S6: magnitude plus half divisor ----------------
   logic [YN_W-1:0]  s6_ymag_ff;
   logic             s6_ysgn_ff;
   logic [DEN_W-1:0] s6_den_ff;
   logic [46:0]      s5_hn_mag;

   assign s5_hn_mag = s5_hn_ff[46] ? 47'(-s5_hn_ff) : 47'(s5_hn_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_ymag_ff <= YN_W'(s5_hn_mag) + YN_W'(s5_den_ff >> 1);
         s6_ysgn_ff <= s5_hn_ff[46];
         s6_den_ff  <= s5_den_ff;
      end
   end

   // ---------------- arithmetic units ----------------
   logic [QUO_W-1:0]  z_quo;
   logic [QUO_W-1:0]  y_quo;
   logic [ROLL_W-1:0] roll_res;

   cwpg_div #(
      .NUM_W (ZN_W),
      .DEN_W (COUNT_W),
      .QUO_W (QUO_W)
   ) u_div_z (
      .clock (clock),
      .en    (adv),
      .num   (s3_zn_ff),
      .den   (cfg_q),
      .quo   (z_quo)
   );

   cwpg_div #(
      .NUM_W (YN_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_div_y (
      .clock (clock),
      .en    (adv),
      .num   (s6_ymag_ff),
      .den   (s6_den_ff),
      .quo   (y_quo)
   );

   cwpg_cordic u_cordic (
      .clock (clock),
      .en    (adv),
      .x_in  (s5_xa_ff),
      .y_in  (s5_ya_ff),
      .roll  (roll_res)
   );

   // ---------------- alignment to S_LAST ----------------
   logic [QUO_W-1:0] zdl_ff   [Z_DLY];
   logic [QUO_W-1:0] ydl_ff   [Y_DLY];
   logic             sgndl_ff [SGN_DLY];
   logic             errdl_ff [ERR_DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         zdl_ff[0]   <= z_quo;
         ydl_ff[0]   <= y_quo;
         sgndl_ff[0] <= s6_ysgn_ff;
         errdl_ff[0] <= s1_err_ff;
         for (int k = 1; k < Z_DLY; k++)   zdl_ff[k]   <= zdl_ff[k-1];
         for (int k = 1; k < Y_DLY; k++)   ydl_ff[k]   <= ydl_ff[k-1];
         for (int k = 1; k < SGN_DLY; k++) sgndl_ff[k] <= sgndl_ff[k-1];
         for (int k = 1; k < ERR_DLY; k++) errdl_ff[k] <= errdl_ff[k-1];
      end
   end

   // ---------------- output register ----------------
   logic                      last_err;
   logic [POS_Y_W-1:0]        last_y;
   logic [POS_Z_W-1:0]        pos_z_ff;
   logic signed [POS_Y_W-1:0] pos_y_ff;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic                      err_ff;

   assign last_err = errdl_ff[ERR_DLY-1];
   assign last_y   = sgndl_ff[SGN_DLY-1] ? POS_Y_W'(0) - ydl_ff[Y_DLY-1] : ydl_ff[Y_DLY-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_z_ff <= last_err ? '0 : zdl_ff[Z_DLY-1];
         pos_y_ff <= last_err ? '0 : $signed(last_y);
         roll_ff  <= last_err ? '0 : $signed(roll_res);
         err_ff   <= last_err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_roll        = roll_ff;
   assign rsp_index_error = err_ff;

endmodule

/* rtl/cwpg_checker.sv */
// Port-level checks of the cubic waypoint pose generator and their bind.
`timescale 1ns / 1ps

module cwpg_checker import cwpg_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [POS_Z_W-1:0]        rsp_pos_z,
   input logic signed [POS_Y_W-1:0] rsp_pos_y,
   input logic signed [ROLL_W-1:0]  rsp_roll,
   input logic                      rsp_index_error
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_z) && $stable(rsp_pos_y)
         && $stable(rsp_roll) && $stable(rsp_index_error))
      else $error("response changed while stalled");

   // a bad index gives an all-zero pose
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_pos_z == '0 && rsp_pos_y == '0 && rsp_roll == '0)
      else $error("index error with nonzero pose");

   // no response pending means the request side is open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind cubic_waypoint_pose_generator cwpg_checker u_cwpg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pos_z       (rsp_pos_z),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_roll        (rsp_roll),
   .rsp_index_error (rsp_index_error)
);
